// ===== hdl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared constants, codes and record types for the gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int NUM_KEYS = 32;
  localparam int KEY_W    = 5;
  localparam int ADDR_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam logic [31:0] HOLD_THR_RESET = 32'd500;
  localparam logic [31:0] REL_THR_RESET  = 32'd300;
  localparam logic [31:0] HOLD_MS_SAT    = 32'hFFFF_FFFF;
  localparam logic [15:0] CLICKS_SAT     = 16'hFFFF;

  // Item opcodes.
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HOLD_THR = 2'd0;
  localparam logic [1:0] CFG_REL_THR  = 2'd1;

  // Per-key phase codes.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_AGAIN = 3'd2;
  localparam logic [2:0] PH_HELD  = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;

  // Reported gesture codes.
  localparam logic [2:0] G_NONE         = 3'd0;
  localparam logic [2:0] G_PENDING      = 3'd1;
  localparam logic [2:0] G_PRESSED      = 3'd2;
  localparam logic [2:0] G_PRESSED_DONE = 3'd3;
  localparam logic [2:0] G_HELD         = 3'd4;
  localparam logic [2:0] G_HELD_DONE    = 3'd5;

  // One key's table entry.
  typedef struct packed {
    logic [2:0]  phase;
    logic        lock;
    logic [15:0] clicks;
    logic [31:0] hold;
    logic [63:0] stamp;
    logic        active;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [31:0] hold_thr;
    logic [31:0] rel_thr;
  } thr_t;

  typedef struct packed {
    logic [2:0]  gesture;
    logic [15:0] clicks;
    logic [31:0] hold;
    logic        active_now;
    logic        active_prev;
  } res_t;

endpackage

// ===== hdl/bgc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module bgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bgc_update.sv =====
// ----------------------------------------------------------------------------
// Gesture classifier entry update
// Computes one key's next table entry and the reported result from the
// current entry, the scan flags, the timestamp and the thresholds.
// ----------------------------------------------------------------------------
module bgc_update (
  input  logic           opcode,
  input  logic           pressed_edge,
  input  logic           held_level,
  input  logic           released_edge,
  input  logic [63:0]    now_ms,
  input  bgc_pkg::thr_t  thr,
  input  bgc_pkg::entry_t cur,
  output bgc_pkg::entry_t nxt,
  output bgc_pkg::res_t  res
);

  logic        prs;
  logic        hld;
  logic        rel;
  logic [63:0] el;
  logic        el_hi;
  logic        over_hold;
  logic        over_rel;
  logic [32:0] acc;
  logic [31:0] el_sat;

  assign rel       = released_edge;
  assign prs       = pressed_edge & ~released_edge;
  assign hld       = held_level & ~pressed_edge & ~released_edge;
  assign el        = now_ms - cur.stamp;
  assign el_hi     = |el[63:32];
  assign over_hold = el_hi || (el[31:0] > thr.hold_thr);
  assign over_rel  = el_hi || (el[31:0] > thr.rel_thr);
  assign acc       = {1'b0, cur.hold} + {1'b0, el[31:0]};
  assign el_sat    = el_hi ? bgc_pkg::HOLD_MS_SAT : el[31:0];

  always_comb begin
    nxt = cur;
    res = '0;
    if (opcode == bgc_pkg::OP_CLEAR) begin
      nxt      = '0;
      nxt.lock = 1'b1;
    end else begin
      res.active_prev = cur.active;
      nxt.lock        = cur.lock & ~(rel | (~prs & ~hld));
      if (!nxt.lock) begin
        res.active_now = prs | hld;
        case (cur.phase)
          bgc_pkg::PH_FIRST: begin
            if (hld) begin
              if (over_hold) begin
                nxt.phase   = bgc_pkg::PH_HELD;
                nxt.clicks  = '0;
                nxt.hold    = el_sat;
                nxt.stamp   = now_ms;
                res.gesture = bgc_pkg::G_HELD;
              end else begin
                res.gesture = bgc_pkg::G_PENDING;
              end
              res.clicks = nxt.clicks;
              res.hold   = nxt.hold;
            end else if (rel) begin
              nxt.phase   = bgc_pkg::PH_GAP;
              nxt.clicks  = 16'd1;
              nxt.hold    = '0;
              nxt.stamp   = now_ms;
              res.gesture = bgc_pkg::G_PRESSED;
              res.clicks  = 16'd1;
            end else begin
              nxt.phase  = bgc_pkg::PH_IDLE;
              nxt.clicks = '0;
              nxt.hold   = '0;
              nxt.stamp  = '0;
            end
          end
          bgc_pkg::PH_GAP: begin
            if (rel || hld) begin
              nxt.phase  = bgc_pkg::PH_IDLE;
              nxt.clicks = '0;
              nxt.hold   = '0;
              nxt.stamp  = '0;
            end else if (prs) begin
              nxt.phase   = bgc_pkg::PH_AGAIN;
              nxt.hold    = '0;
              nxt.stamp   = now_ms;
              res.gesture = bgc_pkg::G_PENDING;
              res.clicks  = cur.clicks;
            end else if (over_rel) begin
              res.gesture = bgc_pkg::G_PRESSED_DONE;
              res.clicks  = cur.clicks;
              res.hold    = cur.hold;
              nxt.phase   = bgc_pkg::PH_IDLE;
              nxt.clicks  = '0;
              nxt.hold    = '0;
              nxt.stamp   = '0;
            end else begin
              res.gesture = bgc_pkg::G_PENDING;
              res.clicks  = cur.clicks;
              res.hold    = cur.hold;
            end
          end
          bgc_pkg::PH_HELD: begin
            if (hld) begin
              nxt.clicks  = '0;
              nxt.hold    = (el_hi || acc[32]) ? bgc_pkg::HOLD_MS_SAT : acc[31:0];
              nxt.stamp   = now_ms;
              res.gesture = bgc_pkg::G_HELD;
              res.hold    = nxt.hold;
            end else begin
              if (rel) begin
                res.gesture = bgc_pkg::G_HELD_DONE;
                res.clicks  = cur.clicks;
                res.hold    = cur.hold;
              end
              nxt.phase  = bgc_pkg::PH_IDLE;
              nxt.clicks = '0;
              nxt.hold   = '0;
              nxt.stamp  = '0;
            end
          end
          bgc_pkg::PH_AGAIN: begin
            if (hld) begin
              if (over_rel) begin
                res.gesture = bgc_pkg::G_PRESSED_DONE;
                nxt.phase   = bgc_pkg::PH_IDLE;
                nxt.clicks  = '0;
                nxt.hold    = '0;
                nxt.stamp   = '0;
              end else begin
                res.gesture = bgc_pkg::G_PENDING;
              end
              res.clicks = cur.clicks;
              res.hold   = cur.hold;
            end else if (rel) begin
              nxt.phase   = bgc_pkg::PH_GAP;
              nxt.clicks  = (cur.clicks != bgc_pkg::CLICKS_SAT) ? cur.clicks + 16'd1
                                                                : cur.clicks;
              nxt.hold    = '0;
              nxt.stamp   = now_ms;
              res.gesture = bgc_pkg::G_PRESSED;
              res.clicks  = nxt.clicks;
            end else begin
              nxt.phase  = bgc_pkg::PH_IDLE;
              nxt.clicks = '0;
              nxt.hold   = '0;
              nxt.stamp  = '0;
            end
          end
          default: begin
            // Idle, and any code that is never stored.
            if (prs) begin
              nxt.phase   = bgc_pkg::PH_FIRST;
              nxt.clicks  = '0;
              nxt.hold    = '0;
              nxt.stamp   = now_ms;
              res.gesture = bgc_pkg::G_PENDING;
            end else begin
              nxt.phase  = bgc_pkg::PH_IDLE;
              nxt.clicks = '0;
              nxt.hold   = '0;
              nxt.stamp  = '0;
            end
          end
        endcase
      end
      nxt.active = res.active_now;
    end
  end

endmodule

// ===== hdl/button_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier
// Per-key click, multi-click and long-hold detection over a table of keys.
// ----------------------------------------------------------------------------
// Usage:
//   An item is a transaction on the command channel: it is taken at a rising
//   edge where start is high and busy is low. A scan item updates one key's
//   gesture tracking; a clear item zeroes the key and locks it until the key
//   is seen released.
//   Every item produces exactly one result. The result is shown on the result
//   ports for one cycle with done high, after the item has been read and
//   updated, and is taken at the rising edge that ends that cycle.
//   The receiver cannot hold results off; it must take them when done is high.
//   Each item passes two steps: one to read the key's entry from the table
//   memory, one to update it and write it back. Busy is high in the update
//   step, so no new item is taken while one is updated. The last entry
//   written back is also kept in a register and takes precedence over the
//   memory when the same key comes up next.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   sets the hold and release thresholds; it is always ready and should only
//   be used while the block is idle. Unknown indexes are ignored.
//   Reset clears the thresholds to 500 and 300 ms and marks every table entry
//   as unwritten, so each key reads as idle right away with no clearing pass.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [4:0]  key_index,
  input  logic        pressed_edge,
  input  logic        held_level,
  input  logic        released_edge,
  input  logic [63:0] now_ms,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Result channel
  output logic        done,
  output logic [4:0]  key_echo,
  output logic [2:0]  gesture,
  output logic [15:0] clicks,
  output logic [31:0] hold_time_ms,
  output logic        active_now,
  output logic        active_prev
);

  // Item that is being updated in the update step.
  logic        stage;
  logic        s_op;
  logic [4:0]  s_key;
  logic        s_prs;
  logic        s_hld;
  logic        s_rel;
  logic [63:0] s_now;

  logic                              accept;
  logic                              s_in_range;
  logic [bgc_pkg::ADDR_W-1:0]        s_addr;
  logic [bgc_pkg::ADDR_W-1:0]        rd_addr;
  logic [bgc_pkg::NUM_KEYS-1:0]      written;
  logic [bgc_pkg::ENTRY_W-1:0]       ram_rdata;
  bgc_pkg::entry_t                   cur;
  bgc_pkg::entry_t                   nxt;
  bgc_pkg::res_t                     res;
  bgc_pkg::thr_t                     thr;
  logic                              we;

  // The entry last written back, kept for forwarding.
  logic                              fwd_valid;
  logic [bgc_pkg::ADDR_W-1:0]        fwd_addr;
  bgc_pkg::entry_t                   fwd_data;

  assign accept     = start && !busy;
  assign busy       = stage;
  assign cfg_ready  = 1'b1;
  assign rd_addr    = bgc_pkg::ADDR_W'(key_index);
  assign s_addr     = bgc_pkg::ADDR_W'(s_key);
  assign s_in_range = 32'(s_key) < bgc_pkg::NUM_KEYS;
  assign we         = stage && s_in_range;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.hold_thr <= bgc_pkg::HOLD_THR_RESET;
      thr.rel_thr  <= bgc_pkg::REL_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bgc_pkg::CFG_HOLD_THR: thr.hold_thr <= cfg_data;
        bgc_pkg::CFG_REL_THR:  thr.rel_thr  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bgc_ram #(
    .WIDTH (bgc_pkg::ENTRY_W),
    .DEPTH (bgc_pkg::NUM_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (s_addr),
    .wdata (nxt),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // The entry under update: forwarded write-back first, then the memory,
  // and an entry never written since reset reads as all zero.
  always_comb begin
    if (fwd_valid && (fwd_addr == s_addr)) begin
      cur = fwd_data;
    end else if (written[s_addr]) begin
      cur = bgc_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  bgc_update u_update (
    .opcode        (s_op),
    .pressed_edge  (s_prs),
    .held_level    (s_hld),
    .released_edge (s_rel),
    .now_ms        (s_now),
    .thr           (thr),
    .cur           (cur),
    .nxt           (nxt),
    .res           (res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= 1'b0;
      done      <= 1'b0;
      written   <= '0;
      fwd_valid <= 1'b0;
    end else begin
      stage <= accept;
      done  <= stage;
      if (we) begin
        written[s_addr] <= 1'b1;
        fwd_valid       <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_op  <= opcode;
      s_key <= key_index;
      s_prs <= pressed_edge;
      s_hld <= held_level;
      s_rel <= released_edge;
      s_now <= now_ms;
    end
    if (we) begin
      fwd_addr <= s_addr;
      fwd_data <= nxt;
    end
    if (stage) begin
      key_echo <= s_key;
      if (s_in_range) begin
        gesture      <= res.gesture;
        clicks       <= (res.gesture == bgc_pkg::G_NONE) ? 16'd0 : res.clicks;
        hold_time_ms <= (res.gesture == bgc_pkg::G_NONE) ? 32'd0 : res.hold;
        active_now   <= res.active_now;
        active_prev  <= res.active_prev;
      end else begin
        gesture      <= bgc_pkg::G_NONE;
        clicks       <= '0;
        hold_time_ms <= '0;
        active_now   <= 1'b0;
        active_prev  <= 1'b0;
      end
    end
  end

  // A result only follows the update cycle of an accepted item.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  // Busy always drops again after the update cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A result with no gesture carries no counts.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (gesture == bgc_pkg::G_NONE)) |-> (clicks == 16'd0 && hold_time_ms == 32'd0))
    else $error("not-pressed result carries counts");

endmodule
